[hw/rtl/assert_macros.svh]
// assertion macros used by decimal_field_formatter
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge of clk, off while in reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition that must never hold on a rising edge of clk, off while in reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[hw/rtl/dff_pkg.sv]
// shared types and constants of the decimal field formatter
`timescale 1ns / 1ps

package dff_pkg;

  // field widths
  localparam int VALUE_W    = 64;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  // parameter defaults
  localparam int DEF_MAX_WIDTH = 18;
  localparam int DEF_FRAC_BITS = 16;

  // serial datapath: one 16-bit digit per cycle over the accumulator
  localparam int DIG_W     = 16;
  // magnitude at most 2^63 times 10^31 (below 2^103) plus rounding fits 167 bits
  localparam int ACC_MIN_W = 167;
  localparam int NDIG      = (ACC_MIN_W + DIG_W - 1) / DIG_W;
  localparam int ACC_W     = NDIG * DIG_W;
  localparam int XW        = DIG_W + 4;

  // divide by ten through a reciprocal, exact for inputs below 10 * 2^DIG_W
  localparam int DIV_SH    = DIG_W + 7;
  localparam int DIV_RECIP = (1 << DIV_SH) / 10 + 1;
  localparam int RECIP_W   = DIV_SH - 3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SCALE = 2'd1;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] WIDTH_RST = 5'd10;
  localparam logic [CFG_DATA_W-1:0] SCALE_RST = 5'd0;

  // characters
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'd48;

endpackage

[hw/rtl/dff_in_if.sv]
// input channel: one signed fixed-point value per item
`timescale 1ns / 1ps

interface dff_in_if import dff_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

[hw/rtl/dff_out_if.sv]
// result channel: one ascii character per item
`timescale 1ns / 1ps

interface dff_out_if import dff_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] digit_char;
  logic              last_char;

  modport source (output valid, output digit_char, output last_char, input ready);
  modport sink (input valid, input digit_char, input last_char, output ready);
endinterface

[hw/rtl/dff_cfg_if.sv]
// configuration write channel: register index and write data
`timescale 1ns / 1ps

interface dff_cfg_if import dff_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[hw/rtl/decimal_field_formatter.sv]
// fixed-width ascii decimal field formatter, digit-serial datapath
//
//   channel  | dir | handshake      | payload
//   in_if    | in  | valid / ready  | value (64, signed fixed point)
//   out_if   | out | valid / ready  | digit_char (7), last_char (1)
//   cfg_if   | in  | valid / ready  | index (2), data (5)
//
// each item takes field_scale times-ten passes, one rounding pass and max(w - 1, 0) divide-by-ten passes
// over NDIG = 11 sixteen-bit digits, w the digit count, then its characters; a zero-width field emits none.
// each times-ten and each divide-by-ten pass walks the accumulator one digit a cycle.
// a new item is taken once the last character sits in the output register.
// reset is synchronous and active low; no clearing pass, control and configuration registers return to defaults.
// a stalled output holds its character; the formatter waits, nothing is dropped.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimal_field_formatter import dff_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic     clk,
  input  logic     rst_n,
  dff_in_if.sink   in_if,
  dff_out_if.source out_if,
  dff_cfg_if.sink  cfg_if
);

  localparam int IDX_W   = (NDIG > 1) ? $clog2(NDIG) : 1;
  localparam int RND_POS = (FRAC_BITS > 0) ? FRAC_BITS - 1 : 0;
  localparam int RND_IDX = RND_POS / DIG_W;
  localparam int RND_BIT = RND_POS % DIG_W;
  localparam logic [DIG_W-1:0] RND_DIG =
    (FRAC_BITS > 0) ? (DIG_W'(1) << RND_BIT) : '0;
  localparam int PW = XW + RECIP_W;
  localparam logic [CFG_DATA_W-1:0] WMAX = CFG_DATA_W'(MAX_WIDTH);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCALE  = 5'b00010,
    ST_ROUND  = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_EMIT   = 5'b10000
  } state_t;

  state_t                state_r, state_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [3:0]            cr_r, cr_nxt;
  logic [CFG_DATA_W-1:0] scl_left_r, scl_left_nxt;
  logic [CFG_DATA_W-1:0] div_left_r, div_left_nxt;
  logic                  neg_r, neg_nxt;
  logic [CFG_DATA_W-1:0] wc_r, wc_nxt;
  logic [CFG_DATA_W-1:0] emit_r, emit_nxt;
  logic [DIGIT_W-1:0]    digs_r [MAX_WIDTH];
  logic [DIGIT_W-1:0]    digs_nxt [MAX_WIDTH];
  logic                  out_valid_r;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [CFG_DATA_W-1:0] field_width_r;
  logic [CFG_DATA_W-1:0] field_scale_r;

  logic                  in_acc;
  logic                  in_neg;
  logic [VALUE_W-1:0]    mag;
  logic [CFG_DATA_W-1:0] wcm;
  logic [CFG_DATA_W-1:0] wdig;
  logic [CFG_DATA_W-1:0] ndiv;
  logic [DIG_W-1:0]      d_lo;
  logic [DIG_W-1:0]      d_hi;
  logic [DIG_W-1:0]      rnd_digit;
  logic [XW-1:0]         mul_x;
  logic [XW-1:0]         rnd_x;
  logic [ACC_W-1:0]      rnd_full;
  logic [XW-1:0]         div_cur;
  logic [PW-1:0]         div_prod;
  logic [DIG_W-1:0]      div_q;
  logic [XW-1:0]         div_r_full;
  logic [DIGIT_W-1:0]    div_r;
  logic                  last_dig;
  logic                  lead_big;
  logic [DIGIT_W-1:0]    lead;
  logic                  slot_free;
  logic                  first_dig;
  logic                  emit_last;
  logic                  load;
  logic                  push;
  logic                  pop;

  // handshakes
  assign in_acc       = in_if.valid && in_if.ready;
  assign in_if.ready  = (state_r == ST_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_if.valid      = out_valid_r;
  assign out_if.digit_char = out_char_r;
  assign out_if.last_char  = out_last_r;

  // item setup: magnitude and effective width
  assign in_neg = in_if.value[VALUE_W-1];
  assign mag    = in_neg ? (VALUE_W'(0) - VALUE_W'(in_if.value)) : VALUE_W'(in_if.value);
  assign wcm    = (field_width_r > WMAX) ? WMAX : field_width_r;
  assign wdig   = wcm - {{(CFG_DATA_W-1){1'b0}}, in_neg};
  assign ndiv   = (wdig == '0) ? '0 : wdig - CFG_DATA_W'(1);

  // times-ten digit step, lowest digit first
  assign d_lo  = acc_r[DIG_W-1:0];
  assign mul_x = ({4'b0, d_lo} << 3) + ({4'b0, d_lo} << 1) + {{DIG_W{1'b0}}, cr_r};

  // rounding digit step, adds half an lsb of the result
  assign rnd_digit = (idx_r == IDX_W'(RND_IDX)) ? RND_DIG : '0;
  assign rnd_x     = {4'b0, d_lo} + {4'b0, rnd_digit} + {{DIG_W{1'b0}}, cr_r};
  assign rnd_full  = {rnd_x[DIG_W-1:0], acc_r[ACC_W-1:DIG_W]};

  // divide-by-ten digit step, highest digit first
  assign d_hi       = acc_r[ACC_W-1 -: DIG_W];
  assign div_cur    = {cr_r, d_hi};
  assign div_prod   = PW'(div_cur) * PW'(DIV_RECIP);
  assign div_q      = div_prod[DIV_SH +: DIG_W];
  assign div_r_full = div_cur - (({4'b0, div_q} << 3) + ({4'b0, div_q} << 1));
  assign div_r      = div_r_full[DIGIT_W-1:0];

  assign last_dig = (idx_r == IDX_W'(NDIG - 1));

  // leading digit: whatever is left, or zero when it is ten or more
  assign lead_big = (|acc_r[ACC_W-1:DIGIT_W]) || (acc_r[DIGIT_W-1:0] > 4'd9);
  assign lead     = lead_big ? '0 : acc_r[DIGIT_W-1:0];

  // emission bookkeeping
  assign slot_free = !out_valid_r || out_if.ready;
  assign first_dig = (emit_r == {{(CFG_DATA_W-1){1'b0}}, neg_r});
  assign emit_last = (emit_r == wc_r - CFG_DATA_W'(1));

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    acc_nxt      = acc_r;
    idx_nxt      = idx_r;
    cr_nxt       = cr_r;
    scl_left_nxt = scl_left_r;
    div_left_nxt = div_left_r;
    neg_nxt      = neg_r;
    wc_nxt       = wc_r;
    emit_nxt     = emit_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    load         = 1'b0;
    push         = 1'b0;
    pop          = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && wcm != '0) begin
          acc_nxt      = ACC_W'(mag);
          neg_nxt      = in_neg;
          wc_nxt       = wcm;
          div_left_nxt = ndiv;
          scl_left_nxt = field_scale_r;
          idx_nxt      = '0;
          cr_nxt       = '0;
          emit_nxt     = '0;
          state_nxt    = (field_scale_r != '0) ? ST_SCALE : ST_ROUND;
        end
      end
      ST_SCALE: begin
        acc_nxt = {mul_x[DIG_W-1:0], acc_r[ACC_W-1:DIG_W]};
        cr_nxt  = mul_x[XW-1:DIG_W];
        idx_nxt = idx_r + IDX_W'(1);
        if (last_dig) begin
          idx_nxt      = '0;
          cr_nxt       = '0;
          scl_left_nxt = scl_left_r - CFG_DATA_W'(1);
          if (scl_left_r == CFG_DATA_W'(1)) begin
            state_nxt = ST_ROUND;
          end
        end
      end
      ST_ROUND: begin
        acc_nxt = rnd_full;
        cr_nxt  = {3'b0, rnd_x[DIG_W]};
        idx_nxt = idx_r + IDX_W'(1);
        if (last_dig) begin
          acc_nxt   = rnd_full >> FRAC_BITS;
          idx_nxt   = '0;
          cr_nxt    = '0;
          state_nxt = (div_left_r != '0) ? ST_DIVIDE : ST_EMIT;
        end
      end
      ST_DIVIDE: begin
        acc_nxt = {acc_r[ACC_W-DIG_W-1:0], div_q};
        cr_nxt  = div_r;
        idx_nxt = idx_r + IDX_W'(1);
        if (last_dig) begin
          idx_nxt      = '0;
          cr_nxt       = '0;
          push         = 1'b1;
          div_left_nxt = div_left_r - CFG_DATA_W'(1);
          if (div_left_r == CFG_DATA_W'(1)) begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load         = 1'b1;
          out_last_nxt = emit_last;
          emit_nxt     = emit_r + CFG_DATA_W'(1);
          if (neg_r && emit_r == '0) begin
            out_char_nxt = CHAR_MINUS;
          end else if (first_dig) begin
            out_char_nxt = CHAR_ZERO + {3'b0, lead};
          end else begin
            out_char_nxt = CHAR_ZERO + {3'b0, digs_r[0]};
            pop          = 1'b1;
          end
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // low digits wait in a stack, the most recent one on top
  always_comb begin
    digs_nxt = digs_r;
    if (push) begin
      digs_nxt[0] = div_r;
      for (int k = 1; k < MAX_WIDTH; k++) begin
        digs_nxt[k] = digs_r[k-1];
      end
    end else if (pop) begin
      for (int k = 0; k < MAX_WIDTH - 1; k++) begin
        digs_nxt[k] = digs_r[k+1];
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      cr_r        <= '0;
      scl_left_r  <= '0;
      div_left_r  <= '0;
      emit_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      idx_r      <= idx_nxt;
      cr_r       <= cr_nxt;
      scl_left_r <= scl_left_nxt;
      div_left_r <= div_left_nxt;
      emit_r     <= emit_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r      <= acc_nxt;
    neg_r      <= neg_nxt;
    wc_r       <= wc_nxt;
    digs_r     <= digs_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_width_r <= WIDTH_RST;
      field_scale_r <= SCALE_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        REG_FIELD_WIDTH: field_width_r <= cfg_if.data;
        REG_FIELD_SCALE: field_scale_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // checks
  `ASSERT_CLK(a_div_rem, (state_r == ST_DIVIDE) |-> (div_r_full < XW'(10)), "remainder out of range")
  `ASSERT_NEVER(a_scale_ovf, (state_r == ST_SCALE) && last_dig && (mul_x[XW-1:DIG_W] != '0), "scale overflow")
  `ASSERT_CLK(a_emit_cnt, (state_r == ST_EMIT) |-> (emit_r < wc_r), "too many characters")
  `ASSERT_CLK(a_start, (in_acc && wcm != '0) |=> (state_r != ST_IDLE), "item accepted but not started")

endmodule
